@@ src/pcc_pkg.sv @@
// Shared types and constants for the plane crossing counter.
package pcc_pkg;

	// pi/2 in Q2.30 (pi/2 * 2^30), rescaled to the angle width with rounding
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_UPDATE_EVERY     = 2'd0,
		CFG_UPDATE_AT_START  = 2'd1,
		CFG_UPDATE_AT_FINISH = 2'd2,
		CFG_BAND_HALF_WIDTH  = 2'd3
	} cfg_index_t;

	// Termination codes
	typedef enum logic [1:0] {
		TERM_CONTINUE = 2'd0,
		TERM_HORIZON  = 2'd1,
		TERM_BOUNDARY = 2'd2,
		TERM_OTHER    = 2'd3
	} term_code_t;

	localparam int CFG_DATA_W   = 16;
	localparam int UPDATE_W     = 16;
	localparam int BAND_W       = 15;
	localparam int PASS_COUNT_W = 16;

endpackage

@@ src/plane_crossing_counter_unit.sv @@
// Plane crossing counter: decimates polar-angle samples and counts equator crossings.
//
// One polar-angle sample enters per transfer on the s_ group and produces exactly one
// result transfer on the m_ group. A sample is used when the decimation counter reaches
// update_every, or, with update_every at zero, at the start step and/or at any
// terminating step as configured. A used sample farther than band_half_width from pi/2
// is compared with the last stored outside-band sample; a change of side adds one to a
// saturating pass count, limited to +-(2^(COUNT_BITS-1)-1). A zero angle is stored as an
// invalid reference, so the next outside-band sample counts nothing. A horizon
// termination negates the count after the step. Angles are unsigned fixed point with
// pi = round(pi * 2^(ANGLE_BITS-2)), 51472 at 16 bits. Throughput is one sample per clock
// while m_tready stays high; a stalled result register holds the sample in the input
// register. A sample sits in the input register, then the compare/count logic loads the
// result register, which drives m_tvalid. The count state updates as a sample moves into
// the result register, so back-to-back samples see each other's effect. Configuration
// writes take effect at the next clock and are meant for idle time.
module plane_crossing_counter_unit
	import pcc_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_addr,
	input  logic [CFG_DATA_W-1:0]                cfg_data,
	// sample input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((ANGLE_BITS+7)/8)*8-1:0]      s_tdata,  // [ANGLE_BITS-1:0] theta, rest zero
	input  logic [2:0]                           s_tuser,  // [0] at_start, [2:1] term_code
	// result output
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [PASS_COUNT_W-1:0]              m_tdata,  // [15:0] pass_count (signed)
	output logic [1:0]                           m_tuser   // [0] sample_used, [1] crossed
);

	// pi/2 rescaled from Q30 to the angle scale, rounded to nearest
	localparam int SH = 32 - ANGLE_BITS;
	localparam logic [63:0] HALF_RND = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
	localparam logic [63:0] HALF_PI_WIDE = (HALF_PI_Q30 + HALF_RND) >> SH;
	localparam logic [ANGLE_BITS-1:0] HALF_PI = HALF_PI_WIDE[ANGLE_BITS-1:0];

	// compare widths
	localparam int MAG_W = (ANGLE_BITS > BAND_W) ? ANGLE_BITS : BAND_W;
	localparam int CNT_CMP_W = (COUNT_BITS > UPDATE_W) ? COUNT_BITS : UPDATE_W;

	// largest count magnitude
	localparam logic signed [COUNT_BITS-1:0] COUNT_MAX =
		COUNT_BITS'((64'd1 << (COUNT_BITS - 1)) - 64'd1);

	// configuration registers
	logic [UPDATE_W-1:0] update_every_q;
	logic                update_at_start_q;
	logic                update_at_finish_q;
	logic [BAND_W-1:0]   band_half_width_q;

	// tracking state
	logic [COUNT_BITS-1:0]        step_counter_q;
	logic                         last_side_above_q;
	logic                         last_valid_q;
	logic signed [COUNT_BITS-1:0] crossing_count_q;

	// input stage
	logic                  valid_s1;
	logic [ANGLE_BITS-1:0] theta_s1;
	logic                  start_s1;
	term_code_t            term_s1;

	// result register
	logic                    out_valid_q;
	logic [PASS_COUNT_W-1:0] pass_count_q;
	logic                    used_q;
	logic                    crossed_q;

	// datapath
	logic                         advance;
	logic                         fire;
	logic [COUNT_BITS-1:0]        step_inc;
	logic                         used;
	logic                         above;
	logic [ANGLE_BITS-1:0]        mag;
	logic                         outside;
	logic                         crossed;
	logic signed [COUNT_BITS-1:0] count_inc;
	logic signed [COUNT_BITS-1:0] count_next;
	logic signed [31:0]           count_ext;

	// result register frees up when empty or being taken
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_every_q     <= UPDATE_W'(1);
			update_at_start_q  <= 1'b0;
			update_at_finish_q <= 1'b0;
			band_half_width_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_addr))
				CFG_UPDATE_EVERY:     update_every_q     <= cfg_data[UPDATE_W-1:0];
				CFG_UPDATE_AT_START:  update_at_start_q  <= cfg_data[0];
				CFG_UPDATE_AT_FINISH: update_at_finish_q <= cfg_data[0];
				CFG_BAND_HALF_WIDTH:  band_half_width_q  <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			theta_s1 <= s_tdata[ANGLE_BITS-1:0];
			start_s1 <= s_tuser[0];
			term_s1  <= term_code_t'(s_tuser[2:1]);
		end
	end

	// decimation
	assign step_inc = step_counter_q + COUNT_BITS'(1);

	always_comb begin
		if (update_every_q != '0) begin
			used = CNT_CMP_W'(step_inc) >= CNT_CMP_W'(update_every_q);
		end else begin
			used = (update_at_start_q && start_s1) ||
			       (update_at_finish_q && (term_s1 != TERM_CONTINUE));
		end
	end

	// side and dead band; the midpoint itself is never outside
	assign above   = theta_s1 > HALF_PI;
	assign mag     = above ? (theta_s1 - HALF_PI) : (HALF_PI - theta_s1);
	assign outside = MAG_W'(mag) > MAG_W'(band_half_width_q);
	assign crossed = used && outside && last_valid_q && (above != last_side_above_q);

	// saturating increment, then negate on horizon
	assign count_inc  = (crossed && (crossing_count_q < COUNT_MAX)) ?
	                    crossing_count_q + COUNT_BITS'(1) : crossing_count_q;
	assign count_next = (term_s1 == TERM_HORIZON) ? -count_inc : count_inc;
	assign count_ext  = 32'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_counter_q    <= '0;
			last_side_above_q <= 1'b0;
			last_valid_q      <= 1'b0;
			crossing_count_q  <= '0;
		end else if (fire) begin
			if (update_every_q != '0) begin
				step_counter_q <= used ? '0 : step_inc;
			end
			if (used && outside) begin
				last_side_above_q <= above;
				last_valid_q      <= theta_s1 != '0;
			end
			crossing_count_q <= count_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pass_count_q <= count_ext[PASS_COUNT_W-1:0];
			used_q       <= used;
			crossed_q    <= crossed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pass_count_q;
	assign m_tuser  = {crossed_q, used_q};

endmodule
